// File: hdl/fmf_pkg.sv
package fmf_pkg;

  localparam int N_W        = 63;
  localparam int ROOT_W     = 32;
  localparam int ROOT_STEPS = 32;
  localparam int CNT_W      = $clog2(ROOT_STEPS);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic root_step;
    logic setup;
    logic step;
    logic finish;
    logic success;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic square;
    logic stop;
    logic hit;
  } stat_t;

endpackage

// File: hdl/fmf_datapath.sv
module fmf_datapath
  import fmf_pkg::*;
(
  input  logic             clk,
  input  logic [N_W-1:0]   composite,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             found,
  output logic [N_W-1:0]   small_factor,
  output logic [N_W-1:0]   large_factor
);

  logic [N_W-1:0]        n;
  logic [2*ROOT_W-1:0]   pend;
  logic [ROOT_W:0]       rem;
  logic [ROOT_W-1:0]     root;
  logic [N_W-1:0]        a;
  logic [N_W-1:0]        b;
  logic [N_W:0]          s;
  logic signed [N_W+2:0] r;

  logic [ROOT_W+2:0]     rem_shift;
  logic [ROOT_W+1:0]     trial;
  logic                  ge;
  logic [ROOT_W+2:0]     rem_next;
  logic [ROOT_W-1:0]     root_next;
  logic signed [N_W+2:0] two_a1;
  logic signed [N_W+2:0] two_b1;
  logic                  past_n;

  // one result bit of the square root per step
  always_comb begin
    rem_shift = {rem, pend[2*ROOT_W-1 -: 2]};
    trial     = {root, 2'b01};
    ge        = rem_shift >= {1'b0, trial};
    rem_next  = ge ? rem_shift - {1'b0, trial} : rem_shift;
    root_next = {root[ROOT_W-2:0], ge};
  end

  assign two_a1 = $signed({2'b0, a, 1'b1});
  assign two_b1 = $signed({2'b0, b, 1'b1});
  assign past_n = s >= {1'b0, n};

  always_comb begin
    stat.square = (rem == '0);
    stat.hit    = (r == '0) && !past_n;
    stat.stop   = (r == '0) || past_n;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n    <= composite;
      pend <= {1'b0, composite};
      rem  <= '0;
      root <= '0;
    end
    if (cmd.root_step) begin
      pend <= {pend[2*ROOT_W-3:0], 2'b00};
      rem  <= rem_next[ROOT_W:0];
      root <= root_next;
    end
    // a starts one above the floor root, r = a*a - n = 2*root + 1 - rem
    if (cmd.setup) begin
      r <= $signed({(N_W+2-ROOT_W)'(0), root, 1'b1}) -
           $signed({(N_W+2-ROOT_W)'(0), rem});
      a <= {(N_W-ROOT_W)'(0), root} + N_W'(1);
      b <= '0;
      s <= {(N_W+1-ROOT_W)'(0), root} + (N_W+1)'(1);
    end
    // r tracks a*a - b*b - n; walk whichever side brings it toward zero
    if (cmd.step) begin
      if (!r[N_W+2]) begin
        r <= r - two_b1;
        b <= b + N_W'(1);
      end else begin
        r <= r + two_a1;
        a <= a + N_W'(1);
      end
      s <= s + (N_W+1)'(1);
    end
    if (cmd.finish) begin
      found        <= cmd.success;
      small_factor <= cmd.success ? a - b : '0;
      large_factor <= cmd.success ? s[N_W-1:0] : '0;
    end
  end

endmodule

// File: hdl/fmf_ctrl.sv
module fmf_ctrl
  import fmf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  typedef enum logic [3:0] {
    IDLE   = 4'b0001,
    ROOT   = 4'b0010,
    SETUP  = 4'b0100,
    SEARCH = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             done_next;

  assign busy = (state != IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    done_next  = 1'b0;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ROOT;
        end
      end
      ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + CNT_W'(1);
        if (cnt == CNT_W'(ROOT_STEPS - 1)) state_next = SETUP;
      end
      SETUP: begin
        // perfect squares, zero and one end here with no pair
        if (stat.square) begin
          cmd.finish  = 1'b1;
          cmd.success = 1'b0;
          done_next   = 1'b1;
          state_next  = IDLE;
        end else begin
          cmd.setup  = 1'b1;
          state_next = SEARCH;
        end
      end
      SEARCH: begin
        if (stat.stop) begin
          cmd.finish  = 1'b1;
          cmd.success = stat.hit;
          done_next   = 1'b1;
          state_next  = IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

endmodule

// File: hdl/fermat_factorizer.sv
// Fermat factorization of a 63-bit number.
// Input: a transaction is taken on a rising edge with start high and busy low;
// composite is sampled at that edge and busy rises on the next cycle.
// Output: done is high for exactly one cycle when the search ends, with found,
// small_factor and large_factor valid in that cycle (they hold until the next
// search ends). found is 0 with both factors zero for 0, 1, perfect squares,
// primes, numbers that are 2 mod 4, and any number whose only same-parity
// pair is the trivial one.
// Sequence: composite is loaded at the accepting edge, then the bit-serial integer
// square root runs in ROOT, setup in SETUP and the search steps in SEARCH until the
// end is seen; done is high in the next cycle.
// A search step moves either a or b up by one, so the step count is
// (a_final - ceil(sqrt(n))) + b_final, bounded by the point where a + b
// reaches n; it is set by the single add/compare loop of the datapath.
// Perfect squares, 0 and 1 end at setup, with no search steps.
// One transaction is in flight at a time; the next is taken in the cycle
// that done is high.
// The receiver cannot stall: done is a strobe and the result is not held off.
// Reset (rst, synchronous) returns the controller to idle and clears done.
module fermat_factorizer
  import fmf_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [N_W-1:0] composite,
  output logic           done,
  output logic           found,
  output logic [N_W-1:0] small_factor,
  output logic [N_W-1:0] large_factor
);

  cmd_t  cmd;
  stat_t stat;

  fmf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  fmf_datapath u_datapath (
    .clk          (clk),
    .composite    (composite),
    .cmd          (cmd),
    .stat         (stat),
    .found        (found),
    .small_factor (small_factor),
    .large_factor (large_factor)
  );

endmodule
